@@ rtl/core/mec_pkg.sv @@
// Shared types and codes for the multi-car elevator controller.
// No dependencies; every other file in rtl/core refers to this package.
package mec_pkg;

  // Fixed field widths of the request and response transactions
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned REQ_FLR_W  = 4;
  localparam int unsigned CAR_W      = 2;
  localparam int unsigned OUT_FLR_W  = 4;
  localparam int unsigned HEAD_W     = 2;
  localparam int unsigned CFG_W      = 3;

  // Reports per tick are capped at this many cars
  localparam int unsigned RESULT_LIMIT = 4;
  localparam logic [CFG_W-1:0] CARS_RST = 3'd4;

  // Request kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_HALL = 2'd0,
    FUNC_CAR  = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  // Car direction
  typedef enum logic [HEAD_W-1:0] {
    HEAD_UP   = 2'd0,
    HEAD_DOWN = 2'd1,
    HEAD_IDLE = 2'd2
  } heading_e;

  // Response kinds
  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // Car memory port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Outcome of one car step
  typedef struct packed {
    logic stepped;
    logic served;
  } step_sts_t;

endpackage

@@ rtl/core/mec_ifs.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on mec_pkg for the field widths.
interface mec_req_if;
  logic                           valid;
  logic                           ready;
  logic [mec_pkg::FUNC_W-1:0]     func;
  logic [mec_pkg::REQ_FLR_W-1:0]  req_floor;
  logic [mec_pkg::CAR_W-1:0]      req_car;

  modport source (output valid, output func, output req_floor, output req_car, input ready);
  modport sink   (input valid, input func, input req_floor, input req_car, output ready);
endinterface

interface mec_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [mec_pkg::CAR_W-1:0]      car;
  logic [mec_pkg::OUT_FLR_W-1:0]  floor_now;
  logic [mec_pkg::HEAD_W-1:0]     heading;
  logic                           served_stop;
  logic                           last;

  modport source (output valid, output kind, output car, output floor_now, output heading,
                  output served_stop, output last, input ready);
  modport sink   (input valid, input kind, input car, input floor_now, input heading,
                  input served_stop, input last, output ready);
endinterface

@@ rtl/core/multi_car_elevator_controller.sv @@
// Multi-car elevator controller, top level.
// Instantiates mec_car_mem, mec_car_step and mec_seq; depends on mec_pkg and mec_ifs.sv.
//
// Each car's floor, heading and up/down stop maps live as one record in a
// single-port-read car memory with a registered read; unwritten records read as
// ground floor, idle, no stops, so no clearing pass runs after reset. Items are
// handled one at a time and the memory read port sets the pace: a tick does one
// read-modify-write per active car, overlapped with the next car's read, plus the
// accept and the final status release; a car request is a read and a write-back;
// a hall request reads cars in turn until an idle one is found, or falls back to
// car 0 when none is idle. A result waiting in the output register that is not
// taken stalls the walk until it drains.
module multi_car_elevator_controller #(
  parameter int unsigned NUM_CARS   = 4,
  parameter int unsigned NUM_FLOORS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mec_req_if.sink                    req,
  mec_rsp_if.source                  rsp,
  input  logic                       cfg_we_i,
  input  logic [mec_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned FW = $clog2(NUM_FLOORS);
  localparam int unsigned AW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int unsigned RW = FW + mec_pkg::HEAD_W + 2 * NUM_FLOORS;
  localparam logic [RW-1:0] RST_REC =
    {{(2 * NUM_FLOORS){1'b0}}, mec_pkg::HEAD_IDLE, {FW{1'b0}}};

  mec_pkg::mem_ctl_t               mem_ctl;
  mec_pkg::step_sts_t              sts;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic [RW-1:0]                   rd_rec;
  logic [RW-1:0]                   wr_rec;
  logic                            file_op;
  logic [mec_pkg::REQ_FLR_W-1:0]   req_floor;
  logic [FW-1:0]                   new_floor;
  logic [mec_pkg::HEAD_W-1:0]      new_heading;
  logic [NUM_FLOORS-1:0]           new_up;
  logic [NUM_FLOORS-1:0]           new_down;

  // Record layout: {up map, down map, heading, floor}
  assign wr_rec = {new_up, new_down, new_heading, new_floor};

  mec_car_mem #(
    .DEPTH   (NUM_CARS),
    .AW      (AW),
    .RW      (RW),
    .RST_REC (RST_REC)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_rec),
    .rd_data_o (rd_rec)
  );

  mec_car_step #(
    .NUM_FLOORS (NUM_FLOORS),
    .FW         (FW)
  ) u_step (
    .file_i      (file_op),
    .req_floor_i (req_floor),
    .floor_i     (rd_rec[FW-1:0]),
    .heading_i   (rd_rec[FW +: mec_pkg::HEAD_W]),
    .up_i        (rd_rec[RW-1 -: NUM_FLOORS]),
    .down_i      (rd_rec[FW + mec_pkg::HEAD_W +: NUM_FLOORS]),
    .floor_o     (new_floor),
    .heading_o   (new_heading),
    .up_o        (new_up),
    .down_o      (new_down),
    .sts_o       (sts)
  );

  mec_seq #(
    .NUM_CARS   (NUM_CARS),
    .NUM_FLOORS (NUM_FLOORS),
    .AW         (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req           (req),
    .rsp           (rsp),
    .mem_ctl_o     (mem_ctl),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .file_o        (file_op),
    .req_floor_o   (req_floor),
    .cur_heading_i (rd_rec[FW +: mec_pkg::HEAD_W]),
    .new_floor_i   (new_floor),
    .new_heading_i (new_heading),
    .sts_i         (sts)
  );

endmodule

@@ rtl/core/mec_car_mem.sv @@
// Car record memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as the reset record.
// Depends on mec_pkg.
module mec_car_mem #(
  parameter int unsigned    DEPTH   = 4,
  parameter int unsigned    AW      = 2,
  parameter int unsigned    RW      = 38,
  parameter logic [RW-1:0]  RST_REC = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mec_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [RW-1:0]     wr_data_i,
  output logic [RW-1:0]     rd_data_o
);

  logic [RW-1:0]    mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [RW-1:0]    rd_data_q;
  logic             rd_vld_q;

  // Array write and read, read data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : RST_REC;

endmodule

@@ rtl/core/mec_car_step.sv @@
// Per-car update logic: files a stop or advances the car one scan step.
// Purely combinational; depends on mec_pkg.
module mec_car_step #(
  parameter int unsigned NUM_FLOORS = 16,
  parameter int unsigned FW         = 4
) (
  input  logic                             file_i,
  input  logic [mec_pkg::REQ_FLR_W-1:0]    req_floor_i,
  input  logic [FW-1:0]                    floor_i,
  input  logic [mec_pkg::HEAD_W-1:0]       heading_i,
  input  logic [NUM_FLOORS-1:0]            up_i,
  input  logic [NUM_FLOORS-1:0]            down_i,
  output logic [FW-1:0]                    floor_o,
  output logic [mec_pkg::HEAD_W-1:0]       heading_o,
  output logic [NUM_FLOORS-1:0]            up_o,
  output logic [NUM_FLOORS-1:0]            down_o,
  output mec_pkg::step_sts_t               sts_o
);

  localparam int unsigned CW = (FW > mec_pkg::REQ_FLR_W) ? FW : mec_pkg::REQ_FLR_W;

  logic [NUM_FLOORS-1:0]       here;
  logic [NUM_FLOORS-1:0]       req_bit;
  logic                        req_ok;
  logic                        can_rise;
  logic [mec_pkg::HEAD_W-1:0]  head;
  logic                        rest;

  assign here     = NUM_FLOORS'(1) << floor_i;
  assign req_bit  = NUM_FLOORS'(1) << req_floor_i;
  assign req_ok   = 32'(req_floor_i) < 32'(NUM_FLOORS);
  assign can_rise = (32'(floor_i) + 32'd1) < 32'(NUM_FLOORS);

  always_comb begin
    floor_o   = floor_i;
    heading_o = heading_i;
    up_o      = up_i;
    down_o    = down_i;
    sts_o     = '0;
    head      = heading_i;
    rest      = 1'b0;

    if (file_i) begin
      // Stop filing: above goes to the up map, below to the down map
      if (req_ok) begin
        if (CW'(req_floor_i) > CW'(floor_i)) begin
          up_o = up_i | req_bit;
        end else if (CW'(req_floor_i) < CW'(floor_i)) begin
          down_o = down_i | req_bit;
        end
      end
    end else begin
      // An idle car picks a heading, or stays at rest without stops
      if (head != mec_pkg::HEAD_UP && head != mec_pkg::HEAD_DOWN) begin
        if (|up_i) begin
          head = mec_pkg::HEAD_UP;
        end else if (|down_i) begin
          head = mec_pkg::HEAD_DOWN;
        end else begin
          head = mec_pkg::HEAD_IDLE;
          rest = 1'b1;
        end
      end

      if (!rest) begin
        sts_o.stepped = 1'b1;
        if (head == mec_pkg::HEAD_UP) begin
          if (|up_i) begin
            if (|(up_i & here)) begin
              up_o         = up_i & ~here;
              sts_o.served = 1'b1;
            end
            if (|up_o) begin
              if (can_rise) begin
                floor_o = floor_i + FW'(1);
              end
            end else begin
              head = (|down_i) ? mec_pkg::HEAD_DOWN : mec_pkg::HEAD_IDLE;
            end
          end
        end else begin
          if (|down_i) begin
            if (|(down_i & here)) begin
              down_o       = down_i & ~here;
              sts_o.served = 1'b1;
            end
            if (|down_o) begin
              if (floor_i != '0) begin
                floor_o = floor_i - FW'(1);
              end
            end else begin
              head = (|up_i) ? mec_pkg::HEAD_UP : mec_pkg::HEAD_IDLE;
            end
          end
        end
      end
      heading_o = head;
    end
  end

endmodule

@@ rtl/core/mec_seq.sv @@
// Sequencer: takes request transactions, walks the car memory one car per cycle
// while no result waits untaken, holds the car count register and drives the
// response register. Depends on mec_pkg and the channel interfaces in mec_ifs.sv.
module mec_seq #(
  parameter int unsigned NUM_CARS   = 4,
  parameter int unsigned NUM_FLOORS = 16,
  parameter int unsigned AW         = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mec_pkg::CFG_W-1:0]      cfg_wdata_i,
  mec_req_if.sink                        req,
  mec_rsp_if.source                      rsp,
  output mec_pkg::mem_ctl_t              mem_ctl_o,
  output logic [AW-1:0]                  rd_addr_o,
  output logic [AW-1:0]                  wr_addr_o,
  output logic                           file_o,
  output logic [mec_pkg::REQ_FLR_W-1:0]  req_floor_o,
  input  logic [mec_pkg::HEAD_W-1:0]     cur_heading_i,
  input  logic [$clog2(NUM_FLOORS)-1:0]  new_floor_i,
  input  logic [mec_pkg::HEAD_W-1:0]     new_heading_i,
  input  mec_pkg::step_sts_t             sts_i
);

  localparam int unsigned MAX_ACT =
    (NUM_CARS < mec_pkg::RESULT_LIMIT) ? NUM_CARS : mec_pkg::RESULT_LIMIT;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FILE  = 5'b00100,
    S_TICK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [mec_pkg::CFG_W-1:0]        cars_q;
  logic [mec_pkg::CFG_W-1:0]        n_eff;
  logic [mec_pkg::CAR_W-1:0]        cnt_q, cnt_d;
  logic [mec_pkg::CAR_W-1:0]        tgt_q, tgt_d;
  logic                             hall_q, hall_d;
  logic [mec_pkg::REQ_FLR_W-1:0]    floor_q, floor_d;
  logic [mec_pkg::CAR_W-1:0]        rd_idx;
  logic                             last_car;
  logic                             out_free;

  // Response register
  logic                             out_v_q;
  logic                             out_kind_q;
  logic [mec_pkg::CAR_W-1:0]        out_car_q;
  logic [mec_pkg::OUT_FLR_W-1:0]    out_floor_q;
  logic [mec_pkg::HEAD_W-1:0]       out_head_q;
  logic                             out_served_q;
  logic                             out_last_q;
  logic                             out_load;
  logic                             out_kind_n;
  logic [mec_pkg::CAR_W-1:0]        out_car_n;
  logic [mec_pkg::OUT_FLR_W-1:0]    out_floor_n;
  logic [mec_pkg::HEAD_W-1:0]       out_head_n;
  logic                             out_served_n;
  logic                             out_last_n;

  // Holding stage: a status waits here until we know whether it is the last one
  logic                             pend_v_q;
  logic [mec_pkg::CAR_W-1:0]        pend_car_q;
  logic [mec_pkg::OUT_FLR_W-1:0]    pend_floor_q;
  logic [mec_pkg::HEAD_W-1:0]       pend_head_q;
  logic                             pend_served_q;
  logic                             pend_load;
  logic                             pend_clr;

  // Active car count: at least one, at most the car count and the report limit
  always_comb begin
    n_eff = cars_q;
    if (n_eff == '0) begin
      n_eff = mec_pkg::CFG_W'(1);
    end
    if (n_eff > mec_pkg::CFG_W'(MAX_ACT)) begin
      n_eff = mec_pkg::CFG_W'(MAX_ACT);
    end
  end

  assign last_car    = (mec_pkg::CFG_W'(cnt_q) + mec_pkg::CFG_W'(1)) >= n_eff;
  assign out_free    = !out_v_q || rsp.ready;
  assign req.ready   = (state_q == S_IDLE);
  assign file_o      = (state_q == S_FILE);
  assign req_floor_o = floor_q;
  assign rd_addr_o   = AW'(rd_idx);

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    tgt_d        = tgt_q;
    hall_d       = hall_q;
    floor_d      = floor_q;
    mem_ctl_o    = '0;
    rd_idx       = '0;
    wr_addr_o    = AW'(cnt_q);
    out_load     = 1'b0;
    out_kind_n   = mec_pkg::KIND_STATUS;
    out_car_n    = pend_car_q;
    out_floor_n  = pend_floor_q;
    out_head_n   = pend_head_q;
    out_served_n = pend_served_q;
    out_last_n   = 1'b0;
    pend_load    = 1'b0;
    pend_clr     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          unique case (mec_pkg::func_e'(req.func))
            mec_pkg::FUNC_HALL: begin
              mem_ctl_o.rd_en = 1'b1;
              cnt_d           = '0;
              hall_d          = 1'b1;
              floor_d         = req.req_floor;
              state_d         = S_SCAN;
            end
            mec_pkg::FUNC_CAR: begin
              if (mec_pkg::CFG_W'(req.req_car) < n_eff) begin
                mem_ctl_o.rd_en = 1'b1;
                rd_idx          = req.req_car;
                tgt_d           = req.req_car;
                hall_d          = 1'b0;
                floor_d         = req.req_floor;
                state_d         = S_FILE;
              end
            end
            mec_pkg::FUNC_TICK: begin
              mem_ctl_o.rd_en = 1'b1;
              cnt_d           = '0;
              state_d         = S_TICK;
            end
            default: begin
            end
          endcase
        end
      end

      // Look for the first idle car; fall back to car 0
      S_SCAN: begin
        if (cur_heading_i == mec_pkg::HEAD_IDLE) begin
          tgt_d   = cnt_q;
          state_d = S_FILE;
        end else if (last_car) begin
          mem_ctl_o.rd_en = 1'b1;
          tgt_d           = '0;
          state_d         = S_FILE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_idx          = cnt_q + mec_pkg::CAR_W'(1);
          cnt_d           = cnt_q + mec_pkg::CAR_W'(1);
        end
      end

      // Write back the filed stop; hall requests also answer
      S_FILE: begin
        wr_addr_o = AW'(tgt_q);
        if (!hall_q || out_free) begin
          mem_ctl_o.wr_en = 1'b1;
          if (hall_q) begin
            out_load     = 1'b1;
            out_kind_n   = mec_pkg::KIND_DISPATCH;
            out_car_n    = tgt_q;
            out_floor_n  = mec_pkg::OUT_FLR_W'(new_floor_i);
            out_head_n   = new_heading_i;
            out_served_n = 1'b0;
            out_last_n   = 1'b1;
          end
          state_d = S_IDLE;
        end
      end

      // One car per cycle unless a held status cannot move on; the next read overlaps this write-back
      S_TICK: begin
        if (!(sts_i.stepped && pend_v_q && !out_free)) begin
          mem_ctl_o.wr_en = 1'b1;
          if (sts_i.stepped) begin
            out_load  = pend_v_q;
            pend_load = 1'b1;
          end
          if (last_car) begin
            state_d = S_FLUSH;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            rd_idx          = cnt_q + mec_pkg::CAR_W'(1);
            cnt_d           = cnt_q + mec_pkg::CAR_W'(1);
          end
        end
      end

      // Release the held status as the final one
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last_n = 1'b1;
          pend_clr   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cars_q   <= mec_pkg::CARS_RST;
      cnt_q    <= '0;
      tgt_q    <= '0;
      hall_q   <= 1'b0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tgt_q   <= tgt_d;
      hall_q  <= hall_d;
      if (cfg_we_i) begin
        cars_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (rsp.ready) begin
        out_v_q <= 1'b0;
      end
      if (pend_load) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    floor_q <= floor_d;
    if (out_load) begin
      out_kind_q   <= out_kind_n;
      out_car_q    <= out_car_n;
      out_floor_q  <= out_floor_n;
      out_head_q   <= out_head_n;
      out_served_q <= out_served_n;
      out_last_q   <= out_last_n;
    end
    if (pend_load) begin
      pend_car_q    <= cnt_q;
      pend_floor_q  <= mec_pkg::OUT_FLR_W'(new_floor_i);
      pend_head_q   <= new_heading_i;
      pend_served_q <= sts_i.served;
    end
  end

  assign rsp.valid       = out_v_q;
  assign rsp.kind        = out_kind_q;
  assign rsp.car         = out_car_q;
  assign rsp.floor_now   = out_floor_q;
  assign rsp.heading     = out_head_q;
  assign rsp.served_stop = out_served_q;
  assign rsp.last        = out_last_q;

`ifndef SYNTHESIS
  // A held status exists only while a tick is being worked off
  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (state_q == S_TICK || state_q == S_FLUSH))
    else $error("held status outside a tick");

  // Overlapped read and write-back never hit the same car
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.rd_en && mem_ctl_o.wr_en) |-> (rd_addr_o != wr_addr_o))
    else $error("read and write to the same car in one cycle");

  // The tick walk and the hall scan stay within the active cars
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK || state_q == S_SCAN) |-> (mec_pkg::CFG_W'(cnt_q) < n_eff))
    else $error("car counter beyond active cars");

  // A dispatch answer is always the only transaction of its request
  a_dispatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_kind_q == mec_pkg::KIND_DISPATCH) |-> out_last_q)
    else $error("dispatch answer without last");
`endif

endmodule
